// ===== rtl/core/ikc_pkg.sv =====
package ikc_pkg;

  // image geometry and kernel limits
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_KERNEL   = 11;
  localparam int NUM_CHANNELS = 4;
  localparam int COEF_DEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH;
  localparam int KMAX_ODD     = MAX_KERNEL - ((MAX_KERNEL % 2 == 0) ? 1 : 0);

  // field widths
  localparam int REQ_W  = 2;
  localparam int CI_W   = 7;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int KS_W   = 4;
  localparam int NC_W   = 3;
  localparam int WORD_W = NUM_CHANNELS * PIX_W;
  localparam int SLOT_W = $clog2(MAX_KERNEL);
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int ACC_W  = PIX_W + COEF_W + $clog2(COEF_DEPTH);

  // request codes
  localparam logic [REQ_W-1:0] REQ_COEF  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = FH_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KSIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CI_W-1:0]   coef_index;
    logic [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]  in_ch0;
    logic [PIX_W-1:0]  in_ch1;
    logic [PIX_W-1:0]  in_ch2;
    logic [PIX_W-1:0]  in_ch3;
  } ikc_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_ch0;
    logic [PIX_W-1:0] out_ch1;
    logic [PIX_W-1:0] out_ch2;
    logic [PIX_W-1:0] out_ch3;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;
    logic             frame_done;
  } ikc_rsp_t;

  // one kernel tap travelling along the cell row
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [COEF_W-1:0] coef;
    logic              act;
    logic              ok;
    logic              first;
    logic              last;
  } ikc_tap_t;

endpackage

// ===== rtl/core/ikc_cell.sv =====
module ikc_cell import ikc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ikc_tap_t         tap_in,
  output ikc_tap_t         tap_out,
  output logic [ACC_W-1:0] acc,
  output logic             done
);

  logic [PIX_W+COEF_W-1:0] prod;

  // low byte is this cell's channel, the rest moves on shifted down
  always_ff @(posedge clk) begin
    tap_out.word  <= tap_in.word >> PIX_W;
    tap_out.coef  <= tap_in.coef;
    tap_out.ok    <= tap_in.ok;
    tap_out.first <= tap_in.first;
    tap_out.last  <= tap_in.last;
    prod <= tap_in.ok ? (PIX_W+COEF_W)'(tap_in.word[PIX_W-1:0]) *
                        (PIX_W+COEF_W)'(tap_in.coef) : '0;
    if (tap_out.act) begin
      acc <= tap_out.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (rst) begin
      tap_out.act <= 1'b0;
      done        <= 1'b0;
    end else begin
      tap_out.act <= tap_in.act;
      done        <= tap_out.act & tap_out.last;
    end
  end

endmodule

// ===== rtl/core/image_kernel_convolution.sv =====
// operation: a coefficient load, a register write or a request that completes no output
//   completes in the cycle it is taken; each output pixel is computed one tap per cycle
//   through the single line-store read port, then the cell row drains, then the result
//   side transaction follows; one request at a time, and a request releasing outputs
//   occupies the block until the result side has taken its last output
// reset: synchronous, active high; registers return to defaults, position counters to
//   zero; no clearing pass, coefficients are undefined until loaded
module image_kernel_convolution import ikc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  ikc_req_t              req_item,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output ikc_rsp_t              rsp_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TAP   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [KS_W-1:0] kernel_size;
  logic [NC_W-1:0] channel_count;

  // effective settings after clamping
  logic [FW_W-1:0]   eff_w;
  logic [FH_W-1:0]   eff_h;
  logic [KS_W-1:0]   eff_k;
  logic [KS_W-2:0]   off;
  logic [NC_W-1:0]   eff_nc;

  // frame position counters
  logic [FH_W-1:0]   in_row;
  logic [COL_W-1:0]  in_col;
  logic [SLOT_W-1:0] in_slot;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  // tap sequencer
  logic [KS_W-1:0]   tap_dx;
  logic [KS_W-1:0]   tap_dy;
  logic [CI_W-1:0]   tap_ci;
  logic [SLOT_W-1:0] tap_slot;
  logic [FH_W-1:0]   row_sum;
  logic [FW_W-1:0]   col_sum;

  // memories
  logic [WORD_W-1:0] line_mem [LINE_DEPTH];
  logic [COEF_W-1:0] coef_mem [COEF_DEPTH];

  ikc_tap_t         stg;
  ikc_tap_t         chain [NUM_CHANNELS+1];
  logic [ACC_W-1:0] acc   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cdone;

  logic              acc_in;
  logic [COL_W-1:0]  jc;
  logic              last_col;
  logic              pix_take;
  logic              drn_take;
  logic              step_take;
  logic              emit_go;
  logic [FW_W-1:0]   col_adv;
  logic              in_wrap;
  logic [SLOT_W:0]   base_sum;
  logic [SLOT_W-1:0] base_slot;
  logic [FW_W-1:0]   c1;
  logic              out_wrap;
  logic [COL_W-1:0]  nxt_col;
  logic [ROW_W-1:0]  nxt_row;
  logic              done_px;
  logic              stop_run;
  logic              last_tap;
  logic              tap_ok;
  logic [FW_W-1:0]   xx;
  logic [LINE_AW-1:0] raddr;
  logic [LINE_AW-1:0] waddr;
  logic [WORD_W-1:0] wword;
  logic [PIX_W-1:0]  in_px [4];
  logic [PIX_W-1:0]  och   [4];

  assign cfg_ready = 1'b1;
  // a register write holds off the request side for its cycle
  assign req_stall = (state != S_IDLE) || cfg_valid;
  assign acc_in    = req_valid && !req_stall;

  // clamp the registers to their legal ranges
  always_comb begin
    eff_w = (frame_width == '0) ? FW_W'(1) :
            (frame_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : frame_width;
    eff_h = (frame_height == '0) ? FH_W'(1) :
            (frame_height > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : frame_height;
    eff_k = kernel_size | KS_W'(1);
    if (eff_k > KS_W'(MAX_KERNEL)) begin
      eff_k = KS_W'(KMAX_ODD);
    end
    off    = eff_k[KS_W-1:1];
    eff_nc = (channel_count == '0) ? NC_W'(1) :
             (channel_count > NC_W'(NUM_CHANNELS)) ? NC_W'(NUM_CHANNELS) : channel_count;
  end

  // input position and what this transaction releases
  always_comb begin
    jc = ({1'b0, in_col} >= eff_w) ? COL_W'(eff_w - FW_W'(1)) : in_col;
    last_col  = ({1'b0, jc} == eff_w - FW_W'(1));
    pix_take  = (req_item.req_type == REQ_PIXEL) && (in_row < eff_h);
    drn_take  = (req_item.req_type == REQ_DRAIN) && (in_row >= eff_h) &&
                ({1'b0, in_row} < {1'b0, eff_h} + (FH_W+1)'(off));
    step_take = pix_take || drn_take;
    // outputs of row i-off up to column j-off, or the whole row at row end
    emit_go   = (in_row >= FH_W'(off)) &&
                (last_col || ({1'b0, out_col} + FW_W'(off) <= {1'b0, jc}));
    col_adv   = {1'b0, jc} + FW_W'(1);
    in_wrap   = (col_adv >= eff_w);
  end

  // ring row holding image row r-off, where r = i-off is the output row
  always_comb begin
    base_sum  = (SLOT_W+1)'(in_slot) + (SLOT_W+1)'(MAX_KERNEL) - (SLOT_W+1)'({off, 1'b0});
    base_slot = (base_sum >= (SLOT_W+1)'(MAX_KERNEL)) ?
                SLOT_W'(base_sum - (SLOT_W+1)'(MAX_KERNEL)) : SLOT_W'(base_sum);
  end

  // output position bookkeeping
  always_comb begin
    c1       = {1'b0, out_col} + FW_W'(1);
    out_wrap = (c1 >= eff_w);
    nxt_col  = out_wrap ? '0 : c1[COL_W-1:0];
    nxt_row  = out_wrap ? out_row + ROW_W'(1) : out_row;
    done_px  = ({1'b0, out_row} == eff_h - FH_W'(1)) && ({1'b0, out_col} == eff_w - FW_W'(1));
    stop_run = done_px || out_wrap || (!last_col && (c1 + FW_W'(off) > {1'b0, jc}));
  end

  // tap validity: zero padding outside the image
  always_comb begin
    last_tap = (tap_dx == eff_k - KS_W'(1)) && (tap_dy == eff_k - KS_W'(1));
    tap_ok   = (row_sum >= FH_W'(off)) &&
               ({1'b0, row_sum} < {1'b0, eff_h} + (FH_W+1)'(off)) &&
               (col_sum >= FW_W'(off)) &&
               ({1'b0, col_sum} < {1'b0, eff_w} + (FW_W+1)'(off));
    xx       = col_sum - FW_W'(off);
    raddr    = LINE_AW'(tap_slot) * LINE_AW'(MAX_WIDTH) + LINE_AW'(xx[COL_W-1:0]);
    waddr    = LINE_AW'(in_slot) * LINE_AW'(MAX_WIDTH) + LINE_AW'(jc);
  end

  // pack the incoming channels, channel 0 in the low byte
  always_comb begin
    in_px[0] = req_item.in_ch0;
    in_px[1] = req_item.in_ch1;
    in_px[2] = req_item.in_ch2;
    in_px[3] = req_item.in_ch3;
    wword = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      wword[ch*PIX_W +: PIX_W] = in_px[ch];
    end
  end

  // truncate to integer and saturate, unused channels read zero
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      och[ch] = '0;
      if (ch < NUM_CHANNELS && NC_W'(ch) < eff_nc) begin
        och[ch] = (|acc[ch][ACC_W-1:COEF_W+PIX_W]) ? {PIX_W{1'b1}} :
                  acc[ch][COEF_W+PIX_W-1:COEF_W];
      end
    end
  end

  // line store and coefficient store, one write and one registered read each
  always_ff @(posedge clk) begin
    if (acc_in && pix_take) begin
      line_mem[waddr] <= wword;
    end
    if (acc_in && req_item.req_type == REQ_COEF && req_item.coef_index < CI_W'(COEF_DEPTH)) begin
      coef_mem[req_item.coef_index] <= req_item.coef_value;
    end
    stg.word  <= line_mem[raddr];
    stg.coef  <= coef_mem[tap_ci];
    stg.ok    <= tap_ok;
    stg.first <= (tap_ci == '0);
    stg.last  <= last_tap;
    if (rst) begin
      stg.act <= 1'b0;
    end else begin
      stg.act <= (state == S_TAP);
    end
  end

  // row of channel cells, each tap word shifts one cell per cycle
  assign chain[0] = stg;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    ikc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tap_in  (chain[g]),
      .tap_out (chain[g+1]),
      .acc     (acc[g]),
      .done    (cdone[g])
    );
  end

  // control: register writes, accept, sequence taps, wait for the cell row, present result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= FW_W'(1024);
      frame_height  <= FH_W'(1);
      kernel_size   <= KS_W'(3);
      channel_count <= NC_W'(3);
      in_row        <= '0;
      in_col        <= '0;
      in_slot       <= '0;
      out_row       <= '0;
      out_col       <= '0;
      rsp_valid     <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index <= CFG_CHANNELS) begin
      // a write to a defined register restarts the frame, coefficients are kept
      case (cfg_index)
        CFG_WIDTH:    frame_width   <= cfg_wdata[FW_W-1:0];
        CFG_HEIGHT:   frame_height  <= cfg_wdata[FH_W-1:0];
        CFG_KSIZE:    kernel_size   <= cfg_wdata[KS_W-1:0];
        CFG_CHANNELS: channel_count <= cfg_wdata[NC_W-1:0];
        default: ;
      endcase
      in_row  <= '0;
      in_col  <= '0;
      in_slot <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc_in && step_take) begin
            if (emit_go) begin
              state    <= S_TAP;
              tap_dx   <= '0;
              tap_dy   <= '0;
              tap_ci   <= '0;
              tap_slot <= base_slot;
              row_sum  <= FH_W'(out_row);
              col_sum  <= FW_W'(out_col);
            end else begin
              if (in_wrap) begin
                in_col  <= '0;
                in_row  <= in_row + FH_W'(1);
                in_slot <= (in_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : in_slot + SLOT_W'(1);
              end else begin
                in_col <= col_adv[COL_W-1:0];
              end
            end
          end
        end
        S_TAP: begin
          tap_ci <= tap_ci + CI_W'(1);
          if (tap_dx == eff_k - KS_W'(1)) begin
            tap_dx   <= '0;
            tap_dy   <= tap_dy + KS_W'(1);
            col_sum  <= FW_W'(out_col);
            row_sum  <= row_sum + FH_W'(1);
            tap_slot <= (tap_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : tap_slot + SLOT_W'(1);
          end else begin
            tap_dx  <= tap_dx + KS_W'(1);
            col_sum <= col_sum + FW_W'(1);
          end
          if (last_tap) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (cdone[NUM_CHANNELS-1]) begin
            rsp_item.out_ch0     <= och[0];
            rsp_item.out_ch1     <= och[1];
            rsp_item.out_ch2     <= och[2];
            rsp_item.out_ch3     <= och[3];
            rsp_item.out_row     <= out_row;
            rsp_item.out_col     <= out_col;
            rsp_item.last_of_run <= stop_run;
            rsp_item.frame_done  <= done_px;
            rsp_valid            <= 1'b1;
            state                <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            if (rsp_item.frame_done) begin
              // frame complete, back to the top for the next one
              in_row  <= '0;
              in_col  <= '0;
              in_slot <= '0;
              out_row <= '0;
              out_col <= '0;
              state   <= S_IDLE;
            end else begin
              out_col <= nxt_col;
              out_row <= nxt_row;
              if (rsp_item.last_of_run) begin
                state <= S_IDLE;
                if (in_wrap) begin
                  in_col  <= '0;
                  in_row  <= in_row + FH_W'(1);
                  in_slot <= (in_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : in_slot + SLOT_W'(1);
                end else begin
                  in_col <= col_adv[COL_W-1:0];
                end
              end else begin
                state    <= S_TAP;
                tap_dx   <= '0;
                tap_dy   <= '0;
                tap_ci   <= '0;
                tap_slot <= base_slot;
                row_sum  <= FH_W'(nxt_row);
                col_sum  <= FW_W'(nxt_col);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one transaction at a time: nothing taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !rsp_valid)
    else $error("request taken while a result is pending");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.frame_done) |-> rsp_item.last_of_run)
    else $error("frame end not flagged as end of run");

  a_cell_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cdone))
    else $error("two cells finished in the same cycle");

  a_chain_window: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CHANNELS].act |-> (state == S_TAP || state == S_FLUSH))
    else $error("tap left the cell row outside a pixel computation");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (in_slot < SLOT_W'(MAX_KERNEL)) && (tap_slot < SLOT_W'(MAX_KERNEL) || state != S_TAP))
    else $error("line ring slot out of range");

endmodule

// ===== dv/image_kernel_convolution_tb.sv =====
module image_kernel_convolution_tb;
  import ikc_pkg::*;

  // request code that the block must drop without a result
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // generous end-of-run cycle limit
  localparam int CYCLE_LIMIT = 3_000_000;
  // quiet cycles granted after the last expected pixel before a register write
  localparam int SETTLE_CYCLES = 30;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  ikc_req_t              req_item;
  logic                  rsp_valid;
  logic                  rsp_stall;
  ikc_rsp_t              rsp_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  image_kernel_convolution dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // free-running clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // convolution predictor: private copy of registers, coefficients and lines
  // ---------------------------------------------------------------------------
  int unsigned      frame_w_reg, frame_h_reg, ksize_reg, chan_reg;
  logic [15:0]      coef_mem [COEF_DEPTH];
  logic [31:0]      pix_lines [MAX_KERNEL][MAX_WIDTH];
  int               in_row, in_col, out_row, out_col;
  ikc_rsp_t         exp_pix_q [$];

  function automatic int eff_w();
    if (frame_w_reg == 0) return 1;
    if (frame_w_reg > MAX_WIDTH) return MAX_WIDTH;
    return frame_w_reg;
  endfunction

  function automatic int eff_h();
    if (frame_h_reg == 0) return 1;
    if (frame_h_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return frame_h_reg;
  endfunction

  // even sizes round up, oversize clamps to the largest odd size
  function automatic int eff_k();
    int k;
    k = ksize_reg | 1;
    if (k > MAX_KERNEL) k = KMAX_ODD;
    return k;
  endfunction

  function automatic int eff_c();
    if (chan_reg == 0) return 1;
    if (chan_reg > NUM_CHANNELS) return NUM_CHANNELS;
    return chan_reg;
  endfunction

  function automatic void restart_positions();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function automatic void clear_model();
    frame_w_reg = 1024;
    frame_h_reg = 1;
    ksize_reg   = 3;
    chan_reg    = 3;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (pix_lines[i, j]) pix_lines[i][j] = '0;
    restart_positions();
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_WIDTH:    frame_w_reg = data[FW_W-1:0];
      CFG_HEIGHT:   frame_h_reg = data[FH_W-1:0];
      CFG_KSIZE:    ksize_reg   = data[KS_W-1:0];
      CFG_CHANNELS: chan_reg    = data[NC_W-1:0];
      default:      return;
    endcase
    restart_positions();
  endfunction

  // zero-padded window sum for one output pixel, all four channels
  function automatic ikc_rsp_t filter_pixel(int r, int c);
    ikc_rsp_t         o;
    logic [7:0]       ch_out [4];
    longint unsigned  acc;
    int               w, h, ks, nc, off, yy, xx, ci;
    w = eff_w(); h = eff_h(); ks = eff_k(); nc = eff_c(); off = ks / 2;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      if (ch < nc) begin
        for (int dy = 0; dy < ks; dy++) begin
          yy = r + dy - off;
          if (yy < 0 || yy >= h) continue;
          for (int dx = 0; dx < ks; dx++) begin
            xx = c + dx - off;
            ci = dy * ks + dx;
            if (xx < 0 || xx >= w || ci >= COEF_DEPTH) continue;
            acc += longint'((pix_lines[yy % MAX_KERNEL][xx] >> (8 * ch)) & 32'hFF)
                   * longint'(coef_mem[ci]);
          end
        end
        acc = acc >> 16;
        if (acc > 255) acc = 255;
      end
      ch_out[ch] = acc[7:0];
    end
    o.out_ch0     = ch_out[0];
    o.out_ch1     = ch_out[1];
    o.out_ch2     = ch_out[2];
    o.out_ch3     = ch_out[3];
    o.out_row     = r[ROW_W-1:0];
    o.out_col     = c[COL_W-1:0];
    o.last_of_run = 1'b0;
    o.frame_done  = 1'b0;
    return o;
  endfunction

  // one accepted request: update state, queue every pixel it releases
  function automatic void predict_request(ikc_req_t it);
    ikc_rsp_t o;
    int       w, h, off, i, j, lim, n, r, c;
    bit       done;
    w = eff_w(); h = eff_h(); off = eff_k() / 2;
    n = 0;
    done = 0;
    if (it.req_type == REQ_COEF) begin
      if (it.coef_index < COEF_DEPTH) coef_mem[it.coef_index] = it.coef_value;
      return;
    end
    if (it.req_type == REQ_UNUSED) return;
    i = in_row;
    j = in_col;
    if (j >= w) j = w - 1;
    if (it.req_type == REQ_PIXEL) begin
      if (i >= h) return;
      pix_lines[i % MAX_KERNEL][j] = {it.in_ch3, it.in_ch2, it.in_ch1, it.in_ch0};
    end else begin
      // drain tick only counts between the last pixel and the end of the drain
      if (i < h || i >= h + off) return;
    end
    if (i >= off) begin
      lim = (j == w - 1) ? w - 1 : j - off;
      while (out_col <= lim && !done) begin
        r = out_row;
        c = out_col;
        o = filter_pixel(r, c);
        if (r == h - 1 && c == w - 1) begin
          o.frame_done = 1'b1;
          done = 1;
        end
        exp_pix_q.push_back(o);
        n++;
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
          break;
        end
      end
    end
    if (n > 0) exp_pix_q[exp_pix_q.size() - 1].last_of_run = 1'b1;
    if (done) begin
      restart_positions();
    end else begin
      in_col = j + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // edge monitors: transactions are judged on values before the rising edge
  // ---------------------------------------------------------------------------
  logic req_took, cfg_took;
  int   fail_count;
  int   cycle_count;

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    req_took <= !rst && req_valid && !req_stall;
    cfg_took <= !rst && cfg_valid && cfg_ready;
    if (!rst && cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_wdata);
    if (!rst && req_valid && !req_stall) predict_request(req_item);
  end

  // result side: compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin
    ikc_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (exp_pix_q.size() == 0) begin
        $error("unexpected result transaction row %0d col %0d",
               rsp_item.out_row, rsp_item.out_col);
        fail_count++;
      end else begin
        e = exp_pix_q.pop_front();
        check_field("out_ch0", e.out_ch0, rsp_item.out_ch0);
        check_field("out_ch1", e.out_ch1, rsp_item.out_ch1);
        check_field("out_ch2", e.out_ch2, rsp_item.out_ch2);
        check_field("out_ch3", e.out_ch3, rsp_item.out_ch3);
        check_field("out_row", e.out_row, rsp_item.out_row);
        check_field("out_col", e.out_col, rsp_item.out_col);
        check_field("last_of_run", e.last_of_run, rsp_item.last_of_run);
        check_field("frame_done", e.frame_done, rsp_item.frame_done);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result-side back pressure: random stalls plus an optional long hold
  // ---------------------------------------------------------------------------
  int send_idle_pct, recv_idle_pct, hold_left;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left--;
    end else begin
      rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all called at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_req(ikc_req_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_item  = it;
    @(negedge clk);
    while (!req_took) @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data[CFG_DATA_W-1:0];
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // block idle: every expected pixel seen, then a quiet settle period
  task automatic wait_drained();
    while (exp_pix_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned k, int unsigned c);
    wait_drained();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_KSIZE, k);
    write_reg(CFG_CHANNELS, c);
  endtask

  // request with every field random, then the type forced
  function automatic ikc_req_t random_req(logic [REQ_W-1:0] kind);
    ikc_req_t    it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(ikc_req_t)-1:0];
    it.req_type = kind;
    return it;
  endfunction

  function automatic ikc_req_t coef_req(int idx, int unsigned val);
    ikc_req_t it;
    it = random_req(REQ_COEF);
    it.coef_index = idx[CI_W-1:0];
    it.coef_value = val[COEF_W-1:0];
    return it;
  endfunction

  // weights scaled so a window of mid-range pixels stays mostly unsaturated
  task automatic load_kernel(int taps_side);
    int unsigned top;
    top = 131072 / (taps_side * taps_side);
    if (top > 65535) top = 65535;
    for (int t = 0; t < taps_side * taps_side; t++) begin
      if ($urandom_range(0, 7) == 0) send_req(coef_req(t, $urandom_range(0, 65535)));
      else send_req(coef_req(t, $urandom_range(0, top)));
    end
  endtask

  // rewrite a few random taps of the window, the rest keep earlier weights
  task automatic retune_kernel(int taps_side, int count);
    int unsigned top;
    top = 131072 / (taps_side * taps_side);
    if (top > 65535) top = 65535;
    for (int t = 0; t < count; t++) begin
      send_req(coef_req($urandom_range(0, taps_side * taps_side - 1),
                        $urandom_range(0, top)));
    end
  endtask

  task automatic send_pixels(int count);
    for (int p = 0; p < count; p++) send_req(random_req(REQ_PIXEL));
  endtask

  task automatic send_drain(int count);
    for (int p = 0; p < count; p++) send_req(random_req(REQ_DRAIN));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every coefficient slot gets a value so no tap ever reads an unwritten weight;
  // indexes past the store are dropped
  task automatic test_coef_load();
    for (int t = 0; t < COEF_DEPTH; t++) send_req(coef_req(t, $urandom_range(0, 1200)));
    send_req(coef_req(0, 16'hFFFF));
    send_req(coef_req(121, 16'hFFFF));
    send_req(coef_req(127, 16'hFFFF));
  endtask

  // reset geometry, a short partial row
  task automatic test_reset_defaults();
    send_pixels(8);
  endtask

  // register extremes and the clamping rules
  task automatic test_reg_extremes();
    // smallest everything: a single pixel frame, 1x1 kernel, one channel
    set_geometry(1, 1, 1, 1);
    send_req(coef_req(0, 16'hFFFF));
    send_pixels(1);
    // zero registers clamp to one, kernel zero rounds up to one
    set_geometry(0, 0, 0, 0);
    send_req(coef_req(0, 16'h8000));
    send_pixels(1);
    // oversize width, even kernel rounds up, channel count clamps to four
    set_geometry(2047, 1, 2, 7);
    load_kernel(3);
    send_pixels(6);
    // widest row with a 1x1 kernel, a result per pixel
    set_geometry(1024, 1, 1, 4);
    send_req(coef_req(0, 16'hC000));
    send_pixels(16);
    // tallest frame, kernel 15 clamps to 11, a one pixel column; all taps loaded earlier
    set_geometry(1, 8191, 15, 5);
    send_pixels(14);
  endtask

  // drain ticks out of place, unused request code, pixel past the last row
  task automatic test_stray_requests();
    set_geometry(3, 2, 3, 4);
    load_kernel(3);
    send_req(random_req(REQ_UNUSED));
    send_drain(1);
    send_pixels(6);
    send_pixels(1);
    send_req(random_req(REQ_UNUSED));
    send_drain(3);
    send_drain(2);
  endtask

  // one frame with random geometry, some noise; returns the pixels and ticks sent
  task automatic random_frame(output int sent, input bit squeeze);
    int unsigned w, h, k, c;
    int          npix, ndrain, kside;
    bit          whole;
    sent = 0;
    w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 8);
    h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 5);
    k = $urandom_range(0, 15);
    c = $urandom_range(0, 7);
    set_geometry(w, h, k, c);
    kside = eff_k();
    retune_kernel(kside, 3);
    npix = eff_w() * eff_h();
    whole = (npix <= 48);
    if (!whole) npix = $urandom_range(1, 48);
    // long result-side hold while the sender keeps offering pixels
    if (squeeze) hold_left = 600;
    for (int p = 0; p < npix; p++) begin
      case ($urandom_range(0, 19))
        0: send_req(random_req(REQ_UNUSED));
        1: send_req(random_req(REQ_DRAIN));
        2: send_req(coef_req($urandom_range(0, 127), $urandom_range(0, 2000)));
        default: ;
      endcase
      send_pixels(1);
      sent++;
    end
    if (whole) begin
      ndrain = (kside / 2) * eff_w();
      if ($urandom_range(0, 3) == 0) send_pixels(1);
      send_drain(ndrain);
      sent += ndrain;
      if ($urandom_range(0, 3) == 0) send_drain(2);
    end
  endtask

  task automatic test_random_phase(int sender_pct, int receiver_pct, int budget, bit squeeze);
    int sent;
    int total;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    total = 0;
    while (total < budget) begin
      random_frame(sent, squeeze && total == 0);
      total += sent;
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_item      = '0;
    rsp_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WIDTH;
    cfg_wdata     = '0;
    req_took      = 1'b0;
    cfg_took      = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    clear_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_coef_load();
    test_reset_defaults();
    test_reg_extremes();
    test_stray_requests();
    // sender sparse, receiver busy; the first frame carries the long hold
    test_random_phase(33, 68, 50, 1'b1);
    // roles swapped
    test_random_phase(68, 33, 50, 1'b0);
    // full rate on both sides
    test_random_phase(0, 0, 50, 1'b0);

    wait_drained();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && exp_pix_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ikc_pkg.sv
rtl/core/ikc_cell.sv
rtl/core/image_kernel_convolution.sv
dv/image_kernel_convolution_tb.sv
